>>> design/block_request_merger_unit_defines.svh
// Assertion macros used by the request merger back end.
`ifndef BLOCK_REQUEST_MERGER_UNIT_DEFINES_SVH
`define BLOCK_REQUEST_MERGER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BRM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BRM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/brm_pkg.sv
// Types and constants shared by the request merger modules.
`timescale 1ns / 1ps

package brm_pkg;

    localparam int START_W    = 63;
    localparam int BYTES_W    = 32;
    localparam int SEG_W      = 11;
    localparam int SECTOR_W   = 23;   // sectors of one request at the smallest sector size
    localparam int SECS_W     = 24;   // sectors of an open run
    localparam int END_W      = 64;
    localparam int LEN_W      = 11;
    localparam int IDX_OUT_W  = 10;
    localparam int IOV_W      = 11;
    localparam int MAXSEC_W   = 22;
    localparam int IN_DATA_W  = 112;
    localparam int OUT_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [IOV_W-1:0]    MAX_IOV_RST     = 11'd1024;
    localparam logic [MAXSEC_W-1:0] MAX_SECTORS_RST = 22'h3FFFFF;
    localparam logic [LEN_W-1:0]    LEN_MAX         = 11'h7FF;

    // Register selects, taken from paddr[2].
    localparam logic REG_MAX_IOV     = 1'b0;
    localparam logic REG_MAX_SECTORS = 1'b1;

    // One classified request as it waits between the front and back parts.
    typedef struct packed {
        logic [START_W-1:0]  start_sector;
        logic [END_W-1:0]    end_sector;     // start_sector plus sectors
        logic [SECTOR_W-1:0] sectors;
        logic [SEG_W-1:0]    segment_count;
        logic                batch_end;
    } entry_t;

    // One merged run on its way out.
    typedef struct packed {
        logic                 last_run;
        logic                 direct;
        logic [SEG_W-1:0]     run_segments;
        logic [LEN_W-1:0]     run_length;
        logic [IDX_OUT_W-1:0] run_first_index;
    } result_t;

endpackage

>>> design/brm_front.sv
// Front part: accepts requests, converts bytes to sectors and queues them.
`timescale 1ns / 1ps

module brm_front #(
    parameter int SECTOR_BYTES = 512
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // s_tdata: start_sector[62:0], byte_length[94:63], segment_count[105:95], zero fill
    input  logic [brm_pkg::IN_DATA_W-1:0] s_tdata,
    input  logic                          s_tlast,
    output logic                          entry_valid,
    output brm_pkg::entry_t               entry,
    input  logic                          entry_pop
);

    localparam int SHIFT = $clog2(SECTOR_BYTES);

    brm_pkg::entry_t new_entry;
    brm_pkg::entry_t slot_reg [2];
    brm_pkg::entry_t slot_next [2];
    logic [1:0]      cnt_reg;
    logic [1:0]      cnt_next;
    logic [1:0]      cnt_mid;
    logic            push;
    logic            pop;

    // Sector size is a power of two, so the sector count is a shift.
    always_comb
    begin
        new_entry.start_sector  = s_tdata[62:0];
        new_entry.sectors       = brm_pkg::SECTOR_W'(s_tdata[94:63] >> SHIFT);
        new_entry.end_sector    = {1'b0, s_tdata[62:0]}
                                  + brm_pkg::END_W'(new_entry.sectors);
        new_entry.segment_count = s_tdata[105:95];
        new_entry.batch_end     = s_tlast;
    end

    assign s_tready    = (cnt_reg != 2'd2);
    assign push        = s_tvalid && s_tready;
    assign pop         = entry_pop && entry_valid;
    assign entry_valid = (cnt_reg != 2'd0);
    assign entry       = slot_reg[0];

    always_comb
    begin
        slot_next[0] = slot_reg[0];
        slot_next[1] = slot_reg[1];
        cnt_mid      = cnt_reg;
        if (pop)
        begin
            slot_next[0] = slot_reg[1];
            cnt_mid      = cnt_reg - 2'd1;
        end
        if (push)
        begin
            if (cnt_mid == 2'd0)
            begin
                slot_next[0] = new_entry;
            end
            else
            begin
                slot_next[1] = new_entry;
            end
        end
        cnt_next = cnt_mid + {1'b0, push};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg[0] <= slot_next[0];
        slot_reg[1] <= slot_next[1];
    end

endmodule

>>> design/brm_back.sv
// Back part: merges queued requests into runs and holds results for output.
`timescale 1ns / 1ps
`include "block_request_merger_unit_defines.svh"

module brm_back #(
    parameter int MAX_BATCH = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [brm_pkg::IOV_W-1:0]      max_iov,
    input  logic [brm_pkg::MAXSEC_W-1:0]   max_sectors,
    input  logic                           entry_valid,
    input  brm_pkg::entry_t                entry,
    output logic                           entry_pop,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // m_tdata: run_first_index[9:0], run_length[20:10], run_segments[31:21]
    output logic [brm_pkg::OUT_DATA_W-1:0] m_tdata,
    // m_tuser: direct
    output logic                           m_tuser,
    output logic                           m_tlast
);

    localparam int IDX_W = $clog2(MAX_BATCH);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_BATCH - 1);
    localparam int SEGSUM_W = brm_pkg::SEG_W + 1;
    localparam int SECSUM_W = brm_pkg::SECS_W + 1;

    // Open run state.
    logic [IDX_W-1:0]             idx_reg, idx_next;
    logic [brm_pkg::LEN_W-1:0]    open_len_reg, open_len_next;
    logic [IDX_W-1:0]             open_first_reg, open_first_next;
    logic [brm_pkg::SEG_W-1:0]    open_segs_reg, open_segs_next;
    logic [brm_pkg::SECS_W-1:0]   open_secs_reg, open_secs_next;
    logic [brm_pkg::END_W-1:0]    open_end_reg, open_end_next;

    // Merge decision.
    logic [SEGSUM_W-1:0]          seg_sum;
    logic [SECSUM_W-1:0]          sec_sum;
    logic                         fits_iov;
    logic                         fits_sec;
    logic                         contiguous;
    logic                         is_direct;
    logic                         has_open;
    logic                         close_run;
    logic                         opening;
    logic [IDX_W-1:0]             new_first;
    logic [brm_pkg::LEN_W-1:0]    new_len;
    logic [brm_pkg::SEG_W-1:0]    new_segs;
    logic [brm_pkg::SECS_W-1:0]   new_secs;
    logic [brm_pkg::END_W-1:0]    new_end;
    brm_pkg::result_t             close_res;
    brm_pkg::result_t             final_res;
    brm_pkg::result_t             res_a;
    logic                         push_a;
    logic                         push_b;
    logic [1:0]                   need;
    logic [2:0]                   room;

    // Output queue: slot 0 drives the port.
    brm_pkg::result_t             oq_reg [2];
    brm_pkg::result_t             oq_next [2];
    logic [1:0]                   oq_cnt_reg, oq_cnt_next;
    logic [1:0]                   oq_cnt_mid;
    logic                         out_pop;

    // Terms watched by the assertions.
    logic                         batch_pop;
    logic                         run_idle;
    logic                         idx_busy;
    logic                         pair_room;

    always_comb
    begin
        seg_sum    = {1'b0, open_segs_reg} + {1'b0, entry.segment_count};
        sec_sum    = {1'b0, open_secs_reg} + SECSUM_W'(entry.sectors);
        fits_iov   = (seg_sum <= SEGSUM_W'(max_iov));
        fits_sec   = (sec_sum <= SECSUM_W'(max_sectors));
        contiguous = (open_end_reg == {1'b0, entry.start_sector});
        is_direct  = entry.batch_end && (idx_reg == '0);
        has_open   = (open_len_reg != '0);
        close_run  = !is_direct && has_open && !(fits_iov && fits_sec && contiguous);
        opening    = !has_open || close_run;

        if (opening)
        begin
            new_first = idx_reg;
            new_len   = brm_pkg::LEN_W'(1);
            new_segs  = entry.segment_count;
            new_secs  = brm_pkg::SECS_W'(entry.sectors);
            new_end   = entry.end_sector;
        end
        else
        begin
            new_first = open_first_reg;
            new_len   = (open_len_reg == brm_pkg::LEN_MAX) ? open_len_reg
                                                           : open_len_reg + 1'b1;
            new_segs  = seg_sum[brm_pkg::SEG_W-1:0];
            new_secs  = sec_sum[brm_pkg::SECS_W-1:0];
            new_end   = open_end_reg + brm_pkg::END_W'(entry.sectors);
        end

        close_res.run_first_index = brm_pkg::IDX_OUT_W'(open_first_reg);
        close_res.run_length      = open_len_reg;
        close_res.run_segments    = open_segs_reg;
        close_res.direct          = 1'b0;
        close_res.last_run        = 1'b0;

        if (is_direct)
        begin
            final_res.run_first_index = '0;
            final_res.run_length      = brm_pkg::LEN_W'(1);
            final_res.run_segments    = '0;
            final_res.direct          = 1'b1;
        end
        else
        begin
            final_res.run_first_index = brm_pkg::IDX_OUT_W'(new_first);
            final_res.run_length      = new_len;
            final_res.run_segments    = new_segs;
            final_res.direct          = 1'b0;
        end
        final_res.last_run = 1'b1;

        res_a = close_run ? close_res : final_res;
        need  = {1'b0, close_run || entry.batch_end} + {1'b0, close_run && entry.batch_end};
    end

    // An item is taken only when the output queue has room for all its runs.
    assign out_pop   = m_tvalid && m_tready;
    assign room      = 3'd2 - {1'b0, oq_cnt_reg} + {2'b0, out_pop};
    assign entry_pop = entry_valid && ({1'b0, need} <= room);
    assign push_a    = entry_pop && (close_run || entry.batch_end);
    assign push_b    = entry_pop && close_run && entry.batch_end;

    always_comb
    begin
        idx_next        = idx_reg;
        open_len_next   = open_len_reg;
        open_first_next = open_first_reg;
        open_segs_next  = open_segs_reg;
        open_secs_next  = open_secs_reg;
        open_end_next   = open_end_reg;
        if (entry_pop)
        begin
            if (entry.batch_end)
            begin
                idx_next        = '0;
                open_len_next   = '0;
                open_first_next = '0;
                open_segs_next  = '0;
                open_secs_next  = '0;
                open_end_next   = '0;
            end
            else
            begin
                idx_next        = (idx_reg == IDX_LAST) ? idx_reg : idx_reg + 1'b1;
                open_len_next   = new_len;
                open_first_next = new_first;
                open_segs_next  = new_segs;
                open_secs_next  = new_secs;
                open_end_next   = new_end;
            end
        end
    end

    always_comb
    begin
        oq_next[0] = oq_reg[0];
        oq_next[1] = oq_reg[1];
        oq_cnt_mid = oq_cnt_reg;
        if (out_pop)
        begin
            oq_next[0] = oq_reg[1];
            oq_cnt_mid = oq_cnt_reg - 2'd1;
        end
        if (push_a)
        begin
            if (oq_cnt_mid == 2'd0)
            begin
                oq_next[0] = res_a;
            end
            else
            begin
                oq_next[1] = res_a;
            end
        end
        // A second run only comes with an empty queue after the pop.
        if (push_b)
        begin
            oq_next[1] = final_res;
        end
        oq_cnt_next = oq_cnt_mid + {1'b0, push_a} + {1'b0, push_b};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg        <= '0;
            open_len_reg   <= '0;
            open_first_reg <= '0;
            open_segs_reg  <= '0;
            open_secs_reg  <= '0;
            open_end_reg   <= '0;
            oq_cnt_reg     <= 2'd0;
        end
        else
        begin
            idx_reg        <= idx_next;
            open_len_reg   <= open_len_next;
            open_first_reg <= open_first_next;
            open_segs_reg  <= open_segs_next;
            open_secs_reg  <= open_secs_next;
            open_end_reg   <= open_end_next;
            oq_cnt_reg     <= oq_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        oq_reg[0] <= oq_next[0];
        oq_reg[1] <= oq_next[1];
    end

    assign m_tvalid = (oq_cnt_reg != 2'd0);
    assign m_tdata  = {oq_reg[0].run_segments, oq_reg[0].run_length,
                       oq_reg[0].run_first_index};
    assign m_tuser  = oq_reg[0].direct;
    assign m_tlast  = oq_reg[0].last_run;

    assign batch_pop = entry_pop && entry.batch_end;
    assign run_idle  = (idx_reg == '0) && (open_len_reg == '0);
    assign idx_busy  = (idx_reg != '0);
    assign pair_room = (oq_cnt_reg == 2'd0) || ((oq_cnt_reg == 2'd1) && m_tready);

    `BRM_ASSERT_NOW(a_oq_bound, clk, rst_n, 1'b1, oq_cnt_reg != 2'd3, "output queue overfilled")
    `BRM_ASSERT_NEXT(a_batch_clear, clk, rst_n, batch_pop, run_idle, "run state kept after batch")
    `BRM_ASSERT_NOW(a_open_idx, clk, rst_n, 1'b1, has_open == idx_busy, "open run and index differ")
    `BRM_ASSERT_NOW(a_two_runs, clk, rst_n, push_b, pair_room, "two runs pushed without room")

endmodule

>>> design/block_request_merger_unit.sv
// Top level of the request merger: register port, front queue and merge back end.
`timescale 1ns / 1ps

// Channel   | Direction | Content
// s_*       | in        | one disk request per transaction, batch_end on s_tlast
// m_*       | out       | one merged run per transaction, direct on m_tuser, last_run on m_tlast
// APB       | in/out    | max_iov at 0x0, max_sectors at 0x4
//
// One request per cycle while the output queue has room: each merge check is one
// pass through the back end's adders and compares. The request that closes a run
// waits in the front queue, the run in the output queue. A run-closing, batch-ending request
// yields two runs; the output port, one run per cycle while m_tready is high, sets the pace.
// Reset clears both queues, the open run and the batch index, and loads the limits.
// Either side may stall without loss: the front and output queues decouple them.

module block_request_merger_unit #(
    parameter int MAX_BATCH    = 32,
    parameter int SECTOR_BYTES = 512
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // Request stream.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // s_tdata: start_sector[62:0], byte_length[94:63], segment_count[105:95], zero fill
    input  logic [brm_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic                           s_tlast,
    // Run stream.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // m_tdata: run_first_index[9:0], run_length[20:10], run_segments[31:21]
    output logic [brm_pkg::OUT_DATA_W-1:0] m_tdata,
    // m_tuser: direct
    output logic                           m_tuser,
    output logic                           m_tlast,
    // Register port.
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [brm_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [brm_pkg::APB_DATA_W-1:0] pwdata,
    output logic [brm_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);

    logic [brm_pkg::IOV_W-1:0]    max_iov_reg;
    logic [brm_pkg::MAXSEC_W-1:0] max_sectors_reg;
    logic                         cfg_write;
    logic                         entry_valid;
    logic                         entry_pop;
    brm_pkg::entry_t              entry;

    // The register port never waits. Registers are decoded on address bit 2
    // only, since each register occupies one 32-bit word.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_iov_reg     <= brm_pkg::MAX_IOV_RST;
            max_sectors_reg <= brm_pkg::MAX_SECTORS_RST;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                brm_pkg::REG_MAX_IOV:
                begin
                    max_iov_reg <= pwdata[brm_pkg::IOV_W-1:0];
                end
                brm_pkg::REG_MAX_SECTORS:
                begin
                    max_sectors_reg <= pwdata[brm_pkg::MAXSEC_W-1:0];
                end
                default:
                begin
                    max_iov_reg <= max_iov_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            brm_pkg::REG_MAX_IOV:     prdata = brm_pkg::APB_DATA_W'(max_iov_reg);
            brm_pkg::REG_MAX_SECTORS: prdata = brm_pkg::APB_DATA_W'(max_sectors_reg);
            default:                  prdata = '0;
        endcase
    end

    // The front end turns each request into a queue entry with its sector
    // count and the sector just past it already worked out.
    brm_front #(
        .SECTOR_BYTES (SECTOR_BYTES)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .entry_valid (entry_valid),
        .entry       (entry),
        .entry_pop   (entry_pop)
    );

    // The back end holds the open run, decides on each entry whether it
    // joins, and queues closed and final runs for the output.
    brm_back #(
        .MAX_BATCH (MAX_BATCH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .max_iov     (max_iov_reg),
        .max_sectors (max_sectors_reg),
        .entry_valid (entry_valid),
        .entry       (entry),
        .entry_pop   (entry_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule

>>> tb/tb.sv
// Self-checking testbench for the block request merger: directed cases, then random traffic.
`timescale 1ns / 1ps

module tb;

    // Local names for the shared widths, types and register codes.
    localparam int IN_DATA_W  = brm_pkg::IN_DATA_W;
    localparam int OUT_DATA_W = brm_pkg::OUT_DATA_W;
    localparam int START_W    = brm_pkg::START_W;
    localparam int BYTES_W    = brm_pkg::BYTES_W;
    localparam int SEG_W      = brm_pkg::SEG_W;
    localparam int SECTOR_W   = brm_pkg::SECTOR_W;
    localparam int SECS_W     = brm_pkg::SECS_W;
    localparam int END_W      = brm_pkg::END_W;
    localparam int LEN_W      = brm_pkg::LEN_W;
    localparam int IDX_OUT_W  = brm_pkg::IDX_OUT_W;
    localparam int IOV_W      = brm_pkg::IOV_W;
    localparam int MAXSEC_W   = brm_pkg::MAXSEC_W;
    localparam int APB_ADDR_W = brm_pkg::APB_ADDR_W;
    localparam int APB_DATA_W = brm_pkg::APB_DATA_W;

    localparam logic [IOV_W-1:0]    MAX_IOV_RST     = brm_pkg::MAX_IOV_RST;
    localparam logic [MAXSEC_W-1:0] MAX_SECTORS_RST = brm_pkg::MAX_SECTORS_RST;
    localparam logic [LEN_W-1:0]    LEN_MAX         = brm_pkg::LEN_MAX;
    localparam logic                REG_MAX_IOV     = brm_pkg::REG_MAX_IOV;
    localparam logic                REG_MAX_SECTORS = brm_pkg::REG_MAX_SECTORS;

    typedef brm_pkg::result_t result_t;

    // The block is built with its default sizes, and the predictor uses the same values.
    localparam int MAX_BATCH    = 32;
    localparam int SECTOR_BYTES = 512;

    // The run is ended as failed if it goes past this many clock cycles.
    localparam int CYCLE_LIMIT  = 600000;

    // Cycles to wait after the last expected run before the block counts as idle.
    localparam int DRAIN_CYCLES = 8;

    // Width of the zero fill at the top of s_tdata.
    localparam int FILL_W = IN_DATA_W - START_W - BYTES_W - SEG_W;

    // Behaviors of the run receiver, changed at random intervals.
    typedef enum int {
        READY_ALWAYS,
        READY_RANDOM,
        READY_PERIODIC,
        READY_SPARSE
    } ready_mode_e;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    // s_tdata: start_sector[62:0], byte_length[94:63], segment_count[105:95], zero fill
    logic [IN_DATA_W-1:0]   s_tdata;
    logic                   s_tlast;
    logic                   m_tvalid;
    logic                   m_tready;
    // m_tdata: run_first_index[9:0], run_length[20:10], run_segments[31:21]
    logic [OUT_DATA_W-1:0]  m_tdata;
    // m_tuser: direct
    logic                   m_tuser;
    logic                   m_tlast;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [APB_ADDR_W-1:0]  paddr;
    logic [APB_DATA_W-1:0]  pwdata;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    block_request_merger_unit #(
        .MAX_BATCH    (MAX_BATCH),
        .SECTOR_BYTES (SECTOR_BYTES)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // 2 ns clock period.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Merge predictor. It keeps its own copy of the limit registers and of
    // the open run, and turns each accepted request into the runs that the
    // block must emit for it.
    // ------------------------------------------------------------------
    logic [IOV_W-1:0]     limit_iov;
    logic [MAXSEC_W-1:0]  limit_sectors;
    logic [IDX_OUT_W-1:0] batch_pos;
    logic [LEN_W-1:0]     run_len;
    logic [IDX_OUT_W-1:0] run_first;
    logic [SEG_W-1:0]     run_segs;
    logic [SECS_W-1:0]    run_secs;
    logic [END_W-1:0]     run_start;

    // Runs that the block still owes, oldest first.
    result_t expected_runs[$];

    int failure_count;
    int requests_sent;
    int batches_sent;
    int runs_checked;
    int settings_applied;
    int burst_left;

    function automatic void clear_open_run();
        batch_pos = '0;
        run_len   = '0;
        run_first = '0;
        run_segs  = '0;
        run_secs  = '0;
        run_start = '0;
    endfunction

    function automatic void push_run(input logic [IDX_OUT_W-1:0] first,
                                     input logic [LEN_W-1:0] len,
                                     input logic [SEG_W-1:0] segs,
                                     input logic direct, input logic last);
        result_t r;
        r.run_first_index = first;
        r.run_length      = len;
        r.run_segments    = segs;
        r.direct          = direct;
        r.last_run        = last;
        expected_runs.push_back(r);
    endfunction

    function automatic void merge_request(input logic [START_W-1:0] start,
                                          input logic [BYTES_W-1:0] bytes,
                                          input logic [SEG_W-1:0] segs,
                                          input logic batch_end);
        logic [SECTOR_W-1:0] secs;
        logic [END_W-1:0]    follow;
        logic                joins;
        secs = SECTOR_W'(bytes / BYTES_W'(SECTOR_BYTES));

        // A batch of one request bypasses the merge logic entirely.
        if (batch_end && batch_pos == '0)
        begin
            push_run('0, LEN_W'(1), '0, 1'b1, 1'b1);
            clear_open_run();
            return;
        end

        // An open run is closed when the request is not contiguous with it or
        // when either summed limit would be exceeded.
        if (run_len != '0)
        begin
            joins  = 1'b1;
            follow = run_start + END_W'(run_secs);
            if ({1'b0, run_segs} + {1'b0, segs} > {1'b0, limit_iov})
                joins = 1'b0;
            if (25'(run_secs) + 25'(secs) > 25'(limit_sectors))
                joins = 1'b0;
            if (follow != {1'b0, start})
                joins = 1'b0;
            if (!joins)
            begin
                push_run(run_first, run_len, run_segs, 1'b0, 1'b0);
                run_len = '0;
            end
        end

        if (run_len == '0)
        begin
            run_start = {1'b0, start};
            run_first = batch_pos;
            run_segs  = '0;
            run_secs  = '0;
        end
        run_secs = run_secs + SECS_W'(secs);
        run_segs = run_segs + segs;
        if (run_len != LEN_MAX)
            run_len = run_len + 1'b1;

        if (batch_end)
        begin
            push_run(run_first, run_len, run_segs, 1'b0, 1'b1);
            clear_open_run();
            return;
        end

        // The batch index stops at the last slot of a full batch.
        if (batch_pos < IDX_OUT_W'(MAX_BATCH - 1))
            batch_pos = batch_pos + 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Failure reporting: the first ten are shown, the rest only counted.
    // ------------------------------------------------------------------
    function automatic void note_failure(input string what);
        failure_count++;
        if (failure_count <= 10)
            $display("[%0t] %s", $realtime, what);
    endfunction

    // ------------------------------------------------------------------
    // Run checker. Every transaction on the run stream is compared, field
    // by field, with the oldest run the predictor expects.
    // ------------------------------------------------------------------
    result_t got_run;
    result_t want_run;

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1)
        begin
            got_run = result_t'({m_tlast, m_tuser, m_tdata});
            runs_checked++;
            if (expected_runs.size() == 0)
            begin
                note_failure($sformatf(
                    "unexpected run: first=%0d len=%0d segs=%0d direct=%b last=%b",
                    got_run.run_first_index, got_run.run_length, got_run.run_segments,
                    got_run.direct, got_run.last_run));
            end
            else
            begin
                want_run = expected_runs.pop_front();
                if (got_run.run_first_index !== want_run.run_first_index ||
                    got_run.run_length !== want_run.run_length ||
                    got_run.run_segments !== want_run.run_segments ||
                    got_run.direct !== want_run.direct ||
                    got_run.last_run !== want_run.last_run)
                begin
                    note_failure($sformatf({
                        "run mismatch: expected first=%0d len=%0d segs=%0d ",
                        "direct=%b last=%b, got first=%0d len=%0d segs=%0d ",
                        "direct=%b last=%b"},
                        want_run.run_first_index, want_run.run_length, want_run.run_segments,
                        want_run.direct, want_run.last_run,
                        got_run.run_first_index, got_run.run_length, got_run.run_segments,
                        got_run.direct, got_run.last_run));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Run receiver. It switches between always ready, random stalls, a
    // fixed stall pattern and long stalls, each held for a random stretch.
    // ------------------------------------------------------------------
    ready_mode_e ready_mode;
    int          ready_left;
    int          ready_tick;

    always @(posedge clk)
    begin
        if (ready_left == 0)
        begin
            ready_mode = ready_mode_e'($urandom_range(0, 3));
            ready_left = $urandom_range(20, 300);
        end
        ready_left--;
        ready_tick++;
        case (ready_mode)
            READY_ALWAYS:   m_tready <= 1'b1;
            READY_RANDOM:   m_tready <= ($urandom_range(0, 3) != 0);
            READY_PERIODIC: m_tready <= ((ready_tick % 7) > 1);
            default:        m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Watchdog: a hung handshake ends the run as failed.
    int cycle_count;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d runs outstanding.",
                cycle_count, expected_runs.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Request sender. Requests go out in bursts of random length, with random
    // idle gaps between bursts. The predictor sees a request at the edge
    // where it is accepted, so expectations always lead the block's output.
    // ------------------------------------------------------------------
    task automatic send_request(input logic [START_W-1:0] start,
                                input logic [BYTES_W-1:0] bytes,
                                input logic [SEG_W-1:0] segs,
                                input logic batch_end);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 9) == 0) ? 80 : $urandom_range(1, 12);
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 3);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {{FILL_W{1'b0}}, segs, bytes, start};
        s_tlast  <= batch_end;
        do
            @(posedge clk);
        while (s_tready !== 1'b1);
        merge_request(start, bytes, segs, batch_end);
        requests_sent++;
        if (batch_end)
            batches_sent++;
    endtask

    // Stops the sender and waits until every expected run has come out, then
    // lets a few more cycles pass in case a request without a run is still
    // inside the block.
    task automatic wait_idle();
        s_tvalid  <= 1'b0;
        burst_left = 0;
        while (expected_runs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Register port. Transfers run back to back; apb_idle releases the bus
    // once a sequence of transfers is done.
    // ------------------------------------------------------------------
    task automatic apb_write(input logic sel, input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
    endtask

    task automatic apb_read_check(input logic sel, input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {sel, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== value)
            note_failure($sformatf("register %0d read back 0x%0h, expected 0x%0h",
                sel, prdata, value));
    endtask

    task automatic apb_idle();
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Writes both limits once the block is idle and reads them back.
    task automatic program_limits(input logic [IOV_W-1:0] iov,
                                  input logic [MAXSEC_W-1:0] sectors);
        wait_idle();
        apb_write(REG_MAX_IOV, APB_DATA_W'(iov));
        apb_write(REG_MAX_SECTORS, APB_DATA_W'(sectors));
        limit_iov     = iov;
        limit_sectors = sectors;
        apb_read_check(REG_MAX_IOV, APB_DATA_W'(iov));
        apb_read_check(REG_MAX_SECTORS, APB_DATA_W'(sectors));
        apb_idle();
        settings_applied++;
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Both limit registers must read back their reset values.
    task automatic test_register_reset();
        apb_read_check(REG_MAX_IOV, APB_DATA_W'(MAX_IOV_RST));
        apb_read_check(REG_MAX_SECTORS, APB_DATA_W'(MAX_SECTORS_RST));
        apb_idle();
    endtask

    // One-request batches pass through with the direct flag, whatever their
    // length and segments are, including the largest start and length values.
    task automatic test_direct_batches();
        send_request('0, '0, '0, 1'b1);
        send_request({START_W{1'b1}}, {BYTES_W{1'b1}}, SEG_W'(1024), 1'b1);
    endtask

    // Contiguous requests merge into one run, a partial sector does not
    // count, and a gap in the sector space splits the batch. The last batch
    // closes a run and ends itself on the same request, giving two runs.
    task automatic test_contiguous_runs();
        send_request(63'd100, 32'd1024, 11'd3, 1'b0);
        send_request(63'd102, 32'd1023, 11'd4, 1'b0);
        send_request(63'd103, 32'd0, 11'd0, 1'b0);
        send_request(63'd103, 32'd1536, 11'd1, 1'b1);
        send_request(63'd500, 32'd512, 11'd1, 1'b0);
        send_request(63'd900, 32'd512, 11'd2, 1'b1);
    endtask

    // With small limits a run fills exactly to both limits, then breaks on
    // segments, then on segments and sectors at once. An oversized request
    // still opens a run of its own, and nothing may join it afterwards.
    task automatic test_limit_breaks();
        program_limits(11'd4, 22'd8);
        send_request(63'd0, 32'd2048, 11'd2, 1'b0);
        send_request(63'd4, 32'd2048, 11'd2, 1'b0);
        send_request(63'd8, 32'd0, 11'd1, 1'b0);
        send_request(63'd8, 32'd4608, 11'd9, 1'b0);
        send_request(63'd17, 32'd0, 11'd0, 1'b1);
    endtask

    // A run that ends past the top of the 63-bit sector space must not join a
    // request whose start matches the truncated follow-on sector. The last
    // request is larger than max_sectors allows.
    task automatic test_sector_space_top();
        program_limits(MAX_IOV_RST, MAX_SECTORS_RST);
        send_request(63'h7FFF_FFFF_FFFF_FFF6, 32'd10240, 11'd1, 1'b0);
        send_request(63'd10, 32'd512, 11'd1, 1'b0);
        send_request(63'd11, 32'hFFFF_FFFF, 11'd1, 1'b1);
    endtask

    // With both limits at zero only requests adding no segments and no whole
    // sectors may merge.
    task automatic test_zero_limits();
        program_limits('0, '0);
        send_request(63'd50, 32'd511, 11'd0, 1'b0);
        send_request(63'd50, 32'd300, 11'd0, 1'b0);
        send_request(63'd50, 32'd512, 11'd0, 1'b0);
        send_request(63'd51, 32'd0, 11'd0, 1'b0);
        send_request(63'd51, 32'd0, 11'd1, 1'b0);
        send_request(63'd51, 32'd0, 11'd0, 1'b1);
    endtask

    // A long batch whose requests all join one run under the zero limits:
    // the batch index stops at its last slot while the run keeps counting.
    task automatic test_long_run();
        int k;
        for (k = 0; k < 200; k++)
            send_request(63'd7777, 32'($urandom_range(0, SECTOR_BYTES - 1)), '0, k == 199);
    endtask

    // One random batch. Most requests continue the previous one so runs
    // grow long, the rest jump, restart at random or sit near the top of the
    // sector space. Long batches drive the batch index into saturation.
    logic [END_W-1:0] next_sector;

    task automatic send_random_batch();
        int                  len;
        int                  k;
        int                  pick;
        logic [START_W-1:0]  start;
        logic [BYTES_W-1:0]  bytes;
        logic [SEG_W-1:0]    segs;
        pick = $urandom_range(0, 99);
        if (pick < 5)
            len = 1;
        else if (pick < 50)
            len = $urandom_range(1, 4);
        else if (pick < 88)
            len = $urandom_range(5, 12);
        else
            len = $urandom_range(13, 40);

        for (k = 0; k < len; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                start = next_sector[START_W-1:0];
            else if (pick < 82)
                start = next_sector[START_W-1:0] + START_W'($urandom_range(1, 100));
            else if (pick < 90)
                start = START_W'({$urandom, $urandom});
            else if (pick < 95)
                start = START_W'(next_sector - END_W'($urandom_range(0, 3)));
            else
                start = {START_W{1'b1}} - START_W'($urandom_range(0, 2000));

            pick = $urandom_range(0, 99);
            if (pick < 55)
                bytes = BYTES_W'($urandom_range(0, 16) * SECTOR_BYTES);
            else if (pick < 75)
                bytes = BYTES_W'($urandom_range(0, 16) * SECTOR_BYTES
                                 + $urandom_range(1, SECTOR_BYTES - 1));
            else if (pick < 90)
                bytes = BYTES_W'($urandom_range(0, 1 << 20));
            else if (pick < 97)
                bytes = $urandom;
            else
                bytes = $urandom_range(0, 1) ? {BYTES_W{1'b1}} : '0;

            pick = $urandom_range(0, 99);
            if (pick < 65)
                segs = SEG_W'($urandom_range(0, 4));
            else if (pick < 85)
                segs = SEG_W'($urandom_range(0, 64));
            else if (pick < 95)
                segs = SEG_W'($urandom_range(0, 1024));
            else
                segs = $urandom_range(0, 1) ? SEG_W'(1024) : '0;

            send_request(start, bytes, segs, k == len - 1);
            next_sector = {1'b0, start} + END_W'(bytes / BYTES_W'(SECTOR_BYTES));
        end
    endtask

    // Random batches under one limit setting, whole batches only.
    task automatic test_random_traffic(input logic [IOV_W-1:0] iov,
                                       input logic [MAXSEC_W-1:0] sectors,
                                       input int n_requests);
        int target;
        program_limits(iov, sectors);
        target = requests_sent + n_requests;
        while (requests_sent < target)
            send_random_batch();
    endtask

    // ------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------
    initial
    begin
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tlast  <= 1'b0;
        m_tready <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;

        limit_iov     = MAX_IOV_RST;
        limit_sectors = MAX_SECTORS_RST;
        clear_open_run();
        next_sector   = '0;
        burst_left    = 0;
        ready_left    = 0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_register_reset();
        test_direct_batches();
        test_contiguous_runs();
        test_limit_breaks();
        test_sector_space_top();
        test_zero_limits();
        test_long_run();

        test_random_traffic(MAX_IOV_RST, MAX_SECTORS_RST, 130);
        test_random_traffic(11'd16, 22'd64, 130);
        test_random_traffic(11'd1, 22'd1, 130);
        test_random_traffic('0, '0, 130);
        test_random_traffic({IOV_W{1'b1}}, MAX_SECTORS_RST, 130);
        test_random_traffic(IOV_W'($urandom_range(0, 2047)),
                            MAXSEC_W'($urandom_range(0, 4194303)), 130);

        wait_idle();
        repeat (20) @(posedge clk);

        failure_count += expected_runs.size();
        $display("Covered %0d requests in %0d batches under %0d limit settings.",
            requests_sent, batches_sent, settings_applied);
        $display("Checked %0d merged runs, %0d failures.", runs_checked, failure_count);
        if (failure_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+design
design/brm_pkg.sv
design/brm_front.sv
design/brm_back.sv
design/block_request_merger_unit.sv
tb/tb.sv
